// File: design/keyed_rotating_queue_defines.svh
// Assertion macros used by the checker file.
`ifndef KEYED_ROTATING_QUEUE_DEFINES_SVH
`define KEYED_ROTATING_QUEUE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define KRQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define KRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/krq_pkg.sv
// Package: widths, command and status codes, and the front-to-back queue beat type.
`timescale 1ns / 1ps
package krq_pkg;
  localparam int Depth = 16;
  localparam int PayloadBits = 16;
  localparam int CntBits = $clog2(Depth + 1);
  localparam int IdxBits = $clog2(Depth);
  localparam logic [7:0] EmptyMark = 8'd126;

  localparam logic [2:0] CMD_ADD_ID = 3'd0;
  localparam logic [2:0] CMD_ADD_AUTO = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_ROTATE = 3'd3;
  localparam logic [2:0] CMD_LOOKUP = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] key_id;
    logic [PayloadBits-1:0] payload;
  } cmd_t;
endpackage

// File: design/krq_front.sv
// Front part: two-entry command queue between the input port and the engine.
`timescale 1ns / 1ps
module krq_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  krq_pkg::cmd_t in_cmd,
  output logic cmd_valid,
  input  logic cmd_ready,
  output krq_pkg::cmd_t cmd
);
  krq_pkg::cmd_t slot [2];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] fill;
  logic push;
  logic pop;

  assign in_ready = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: design/krq_back.sv
// Back part: cell array with parallel id compare, shifting cells and the result register.
`timescale 1ns / 1ps
module krq_back (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  krq_pkg::cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [7:0] assigned_id,
  output logic [krq_pkg::PayloadBits-1:0] found_value,
  output logic front_valid,
  output logic [7:0] front_id,
  output logic [krq_pkg::PayloadBits-1:0] front_value,
  output logic [4:0] entry_count
);
  localparam int D = krq_pkg::Depth;
  localparam int PB = krq_pkg::PayloadBits;
  localparam int CB = krq_pkg::CntBits;
  localparam int IB = krq_pkg::IdxBits;

  logic [7:0] ids [D];
  logic [PB-1:0] vals [D];
  logic [CB-1:0] occupancy;
  logic [255:0] held;
  logic [D-1:0] hit;
  logic any_hit;
  logic [IB-1:0] hit_idx;
  logic [7:0] auto_id;
  logic auto_ok;
  logic fire;
  logic [1:0] st;
  logic [7:0] asg;
  logic [PB-1:0] fnd;
  logic do_app;
  logic do_rem;
  logic do_rot;
  logic [7:0] app_id;
  logic [CB-1:0] occ_next;

  assign cmd_ready = !out_valid || out_ready;
  assign fire = cmd_valid && cmd_ready;

  always_comb begin
    hit = '0;
    held = '0;
    for (int i = 0; i < D; i++) begin
      if (CB'(i) < occupancy) begin
        hit[i] = (ids[i] == cmd.key_id);
        held[ids[i]] = 1'b1;
      end
    end
    any_hit = |hit;
    hit_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = IB'(i);
    end
    auto_ok = 1'b0;
    auto_id = 8'd0;
    for (int k = 255; k >= 1; k--) begin
      if (!held[k]) begin
        auto_ok = 1'b1;
        auto_id = 8'(k);
      end
    end
  end

  always_comb begin
    st = krq_pkg::ST_OK;
    asg = 8'd0;
    fnd = '0;
    do_app = 1'b0;
    do_rem = 1'b0;
    do_rot = 1'b0;
    app_id = cmd.key_id;
    occ_next = occupancy;
    case (cmd.command)
      krq_pkg::CMD_ADD_ID, krq_pkg::CMD_ADD_AUTO: begin
        if (cmd.command == krq_pkg::CMD_ADD_AUTO) app_id = auto_id;
        if (cmd.command == krq_pkg::CMD_ADD_AUTO && !auto_ok) begin
          st = (cmd.payload == '0) ? krq_pkg::ST_DUP : krq_pkg::ST_FULL;
        end else if ((cmd.command == krq_pkg::CMD_ADD_ID && any_hit) ||
                     cmd.payload == '0) begin
          st = krq_pkg::ST_DUP;
        end else if (occupancy == CB'(D)) begin
          st = krq_pkg::ST_FULL;
        end else begin
          do_app = 1'b1;
          asg = app_id;
          occ_next = occupancy + CB'(1);
        end
      end
      krq_pkg::CMD_REMOVE: begin
        if (!any_hit) st = krq_pkg::ST_MISS;
        else begin
          do_rem = 1'b1;
          occ_next = occupancy - CB'(1);
        end
      end
      krq_pkg::CMD_ROTATE: do_rot = (occupancy > CB'(1));
      krq_pkg::CMD_LOOKUP: begin
        if (!any_hit) st = krq_pkg::ST_MISS;
        else fnd = vals[hit_idx];
      end
      krq_pkg::CMD_CLEAR: occ_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < D; i++) begin
        if (do_app && CB'(i) == occupancy) begin
          ids[i] <= app_id;
          vals[i] <= cmd.payload;
        end
        if ((do_rem && IB'(i) >= hit_idx) || do_rot) begin
          if (do_rot && CB'(i) == occupancy - CB'(1)) begin
            ids[i] <= ids[0];
            vals[i] <= vals[0];
          end else if (i < D - 1) begin
            ids[i] <= ids[i + 1];
            vals[i] <= vals[i + 1];
          end
        end
      end
      status <= st;
      assigned_id <= asg;
      found_value <= fnd;
    end
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) occupancy <= occ_next;
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign front_valid = (occupancy != '0);
  assign front_id = front_valid ? ids[0] : krq_pkg::EmptyMark;
  assign front_value = front_valid ? vals[0] : '0;
  assign entry_count = 5'(occupancy);
endmodule

// File: design/keyed_rotating_queue.sv
// Top level: keyed rotating queue with command queue and cell engine.
// Path: a beat is stored in the command queue, then the engine registers its result.
// Throughput: one command per cycle while out_ready is high; all cells update together.
// Reset: rst synchronously empties the command queue, the result register and the count.
// Cell contents are not reset; cells at or above the count never reach a result or output.
`timescale 1ns / 1ps
module keyed_rotating_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] command,
  input  logic [7:0] key_id,
  input  logic [krq_pkg::PayloadBits-1:0] payload,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [7:0] assigned_id,
  output logic [krq_pkg::PayloadBits-1:0] found_value,
  output logic front_valid,
  output logic [7:0] front_id,
  output logic [krq_pkg::PayloadBits-1:0] front_value,
  output logic [4:0] entry_count
);
  krq_pkg::cmd_t in_cmd;
  krq_pkg::cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  assign in_cmd = '{command: command, key_id: key_id, payload: payload};

  krq_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  krq_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .assigned_id(assigned_id), .found_value(found_value), .front_valid(front_valid),
    .front_id(front_id), .front_value(front_value), .entry_count(entry_count)
  );
endmodule

// File: design/krq_checker.sv
// Checker: port-level properties of the keyed rotating queue, bound to the top level.
`timescale 1ns / 1ps
`include "keyed_rotating_queue_defines.svh"
module krq_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic front_valid,
  input logic [7:0] front_id,
  input logic [4:0] entry_count
);
  `KRQ_ASSERT_IMPL(a_empty_mark, out_valid && !front_valid, front_id == 8'd126)
  `KRQ_ASSERT_IMPL(a_valid_count, out_valid, front_valid == (entry_count != 5'd0))
  `KRQ_ASSERT_IMPL(a_count_range, out_valid, entry_count <= 5'd16)
  `KRQ_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status))
endmodule

bind keyed_rotating_queue krq_checker u_krq_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .front_valid(front_valid), .front_id(front_id), .entry_count(entry_count)
);

// File: dv/tb_top.sv
// Testbench for keyed_rotating_queue: directed table plus random commands, checked by a queue model.
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [1:0] status;
    logic [7:0] assigned_id;
    logic [krq_pkg::PayloadBits-1:0] found_value;
    logic front_valid;
    logic [7:0] front_id;
    logic [krq_pkg::PayloadBits-1:0] front_value;
    logic [4:0] entry_count;
  } reply_t;

  typedef struct {
    logic [2:0] command;
    logic [7:0] key_id;
    logic [krq_pkg::PayloadBits-1:0] payload;
    bit known;
    logic [1:0] status;
    logic [4:0] entry_count;
  } row_t;

  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] command = '0;
  logic [7:0] key_id = '0;
  logic [krq_pkg::PayloadBits-1:0] payload = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic [7:0] assigned_id;
  logic [krq_pkg::PayloadBits-1:0] found_value;
  logic front_valid;
  logic [7:0] front_id;
  logic [krq_pkg::PayloadBits-1:0] front_value;
  logic [4:0] entry_count;

  keyed_rotating_queue dut (.*);

  always #4 clk = ~clk;

  logic [7:0] q_ids[$];
  logic [krq_pkg::PayloadBits-1:0] q_vals[$];
  reply_t pending[$];
  int errors = 0;
  int cycles = 0;
  bit hold_sink = 0;
  bit sink_calm = 0;
  bit src_calm = 0;
  bit done = 0;

  function automatic int find_id(logic [7:0] id);
    foreach (q_ids[i]) if (q_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [1:0] queue_add(logic [7:0] id,
                                           logic [krq_pkg::PayloadBits-1:0] v);
    if (find_id(id) >= 0 || v == 0) return krq_pkg::ST_DUP;
    if (q_ids.size() >= krq_pkg::Depth) return krq_pkg::ST_FULL;
    q_ids.push_back(id);
    q_vals.push_back(v);
    return krq_pkg::ST_OK;
  endfunction

  function automatic reply_t queue_step(logic [2:0] c, logic [7:0] k,
                                        logic [krq_pkg::PayloadBits-1:0] v);
    reply_t r;
    int pos;
    int id;
    r = '{default: '0};
    case (c)
      krq_pkg::CMD_ADD_ID: begin
        r.status = queue_add(k, v);
        if (r.status == krq_pkg::ST_OK) r.assigned_id = k;
      end
      krq_pkg::CMD_ADD_AUTO: begin
        for (id = 1; id < 256; id++) if (find_id(id[7:0]) < 0) break;
        if (id >= 256) r.status = (v == 0) ? krq_pkg::ST_DUP : krq_pkg::ST_FULL;
        else begin
          r.status = queue_add(id[7:0], v);
          if (r.status == krq_pkg::ST_OK) r.assigned_id = id[7:0];
        end
      end
      krq_pkg::CMD_REMOVE: begin
        pos = find_id(k);
        if (pos < 0) r.status = krq_pkg::ST_MISS;
        else begin
          q_ids.delete(pos);
          q_vals.delete(pos);
        end
      end
      krq_pkg::CMD_ROTATE: begin
        if (q_ids.size() > 1) begin
          q_ids.push_back(q_ids.pop_front());
          q_vals.push_back(q_vals.pop_front());
        end
      end
      krq_pkg::CMD_LOOKUP: begin
        pos = find_id(k);
        if (pos < 0) r.status = krq_pkg::ST_MISS;
        else r.found_value = q_vals[pos];
      end
      krq_pkg::CMD_CLEAR: begin
        q_ids.delete();
        q_vals.delete();
      end
      default: ;
    endcase
    r.front_valid = q_ids.size() > 0;
    r.front_id = r.front_valid ? q_ids[0] : krq_pkg::EmptyMark;
    r.front_value = r.front_valid ? q_vals[0] : '0;
    r.entry_count = 5'(q_ids.size());
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic send(logic [2:0] c, logic [7:0] k, logic [krq_pkg::PayloadBits-1:0] v,
                      bit known = 1'b0, logic [1:0] st = krq_pkg::ST_OK,
                      logic [4:0] cnt = 5'd0);
    reply_t r;
    if (!src_calm && $urandom_range(99) < 7) begin
      in_valid <= 0;
      @(negedge clk);
      while (!src_calm && $urandom_range(99) < 7) @(negedge clk);
    end
    in_valid <= 1;
    command <= c;
    key_id <= k;
    payload <= v;
    do @(posedge clk); while (!in_ready);
    r = queue_step(c, k, v);
    if (known && (r.status != st || r.entry_count != cnt))
      report("directed row", 32'({r.status, r.entry_count}), 32'({st, cnt}));
    pending.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(negedge clk); while (pending.size() != 0);
  endtask

  always @(posedge clk) begin
    reply_t w;
    if (!rst) cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) report("unexpected beat", 32'd0, 32'd0);
      else begin
        w = pending.pop_front();
        if (status !== w.status) report("status", 32'(status), 32'(w.status));
        if (assigned_id !== w.assigned_id)
          report("assigned_id", 32'(assigned_id), 32'(w.assigned_id));
        if (found_value !== w.found_value)
          report("found_value", 32'(found_value), 32'(w.found_value));
        if (front_valid !== w.front_valid)
          report("front_valid", 32'(front_valid), 32'(w.front_valid));
        if (front_id !== w.front_id) report("front_id", 32'(front_id), 32'(w.front_id));
        if (front_value !== w.front_value)
          report("front_value", 32'(front_value), 32'(w.front_value));
        if (entry_count !== w.entry_count)
          report("entry_count", 32'(entry_count), 32'(w.entry_count));
      end
    end
  end

  always @(negedge clk)
    out_ready <= !hold_sink && (sink_calm || $urandom_range(99) >= 7);

  initial begin
    wait (cycles >= LIMIT);
    $display("FAIL keyed_rotating_queue");
    $finish;
  end

  initial begin
    wait (done);
    repeat (200) @(posedge clk);
    hold_sink = 1;
    repeat (300) @(posedge clk);
    hold_sink = 0;
  end

  row_t rows [17] = '{
    '{krq_pkg::CMD_REMOVE, 8'd1, 16'd0, 1'b1, krq_pkg::ST_MISS, 5'd0},
    '{krq_pkg::CMD_LOOKUP, 8'd0, 16'd0, 1'b1, krq_pkg::ST_MISS, 5'd0},
    '{krq_pkg::CMD_ROTATE, 8'd0, 16'd0, 1'b1, krq_pkg::ST_OK, 5'd0},
    '{krq_pkg::CMD_ADD_ID, 8'd5, 16'd0, 1'b1, krq_pkg::ST_DUP, 5'd0},
    '{krq_pkg::CMD_ADD_ID, 8'd0, 16'hFFFF, 1'b1, krq_pkg::ST_OK, 5'd1},
    '{krq_pkg::CMD_ADD_ID, 8'd255, 16'd1, 1'b1, krq_pkg::ST_OK, 5'd2},
    '{krq_pkg::CMD_ADD_ID, 8'd255, 16'd7, 1'b1, krq_pkg::ST_DUP, 5'd2},
    '{krq_pkg::CMD_ADD_AUTO, 8'd0, 16'h8000, 1'b1, krq_pkg::ST_OK, 5'd3},
    '{krq_pkg::CMD_ADD_AUTO, 8'd0, 16'd0, 1'b1, krq_pkg::ST_DUP, 5'd3},
    '{krq_pkg::CMD_LOOKUP, 8'd255, 16'd0, 1'b0, krq_pkg::ST_OK, 5'd0},
    '{krq_pkg::CMD_ROTATE, 8'd0, 16'd0, 1'b0, krq_pkg::ST_OK, 5'd0},
    '{krq_pkg::CMD_REMOVE, 8'd0, 16'd0, 1'b0, krq_pkg::ST_OK, 5'd0},
    '{3'd6, 8'd0, 16'd0, 1'b0, krq_pkg::ST_OK, 5'd0},
    '{3'd7, 8'hAA, 16'h5555, 1'b0, krq_pkg::ST_OK, 5'd0},
    '{krq_pkg::CMD_CLEAR, 8'd0, 16'd0, 1'b1, krq_pkg::ST_OK, 5'd0},
    '{krq_pkg::CMD_ADD_ID, 8'd9, 16'h00FF, 1'b1, krq_pkg::ST_OK, 5'd1},
    '{krq_pkg::CMD_ROTATE, 8'd0, 16'd0, 1'b1, krq_pkg::ST_OK, 5'd1}
  };

  initial begin
    int n;
    int c;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (rows[i])
      send(rows[i].command, rows[i].key_id, rows[i].payload,
           rows[i].known, rows[i].status, rows[i].entry_count);
    for (int i = 0; i < 17; i++)
      send(krq_pkg::CMD_ADD_AUTO, 8'd0, 16'($urandom_range(1, 65535)));
    send(krq_pkg::CMD_ADD_ID, 8'd200, 16'd3, 1'b1, krq_pkg::ST_FULL, 5'd16);
    send(krq_pkg::CMD_ADD_ID, 8'd9, 16'd0, 1'b1, krq_pkg::ST_DUP, 5'd16);
    done = 1;
    for (n = 0; n < 950; n++) begin
      src_calm = (n >= 300 && n < 420);
      sink_calm = src_calm;
      if (n == 500) drain();
      c = $urandom_range(99);
      if (c < 30)
        send(krq_pkg::CMD_ADD_ID,
             8'($urandom_range(0, 31) | ($urandom_range(9) == 0 ? $urandom : 0)),
             16'($urandom_range(15) == 0 ? 0 : $urandom));
      else if (c < 45)
        send(krq_pkg::CMD_ADD_AUTO, 8'($urandom),
             16'($urandom_range(15) == 0 ? 0 : $urandom));
      else if (c < 63) send(krq_pkg::CMD_REMOVE, 8'($urandom_range(0, 35)), 16'd0);
      else if (c < 75) send(krq_pkg::CMD_ROTATE, 8'($urandom), 16'($urandom));
      else if (c < 93) send(krq_pkg::CMD_LOOKUP, 8'($urandom_range(0, 35)), 16'($urandom));
      else if (c < 96) send(krq_pkg::CMD_CLEAR, 8'($urandom), 16'($urandom));
      else send(3'($urandom_range(6, 7)), 8'($urandom), 16'($urandom));
    end
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending.size() == 0) $display("PASS keyed_rotating_queue");
    else $display("FAIL keyed_rotating_queue");
    $finish;
  end
endmodule

// File: sim.f
+incdir+design
design/krq_pkg.sv
design/krq_front.sv
design/krq_back.sv
design/keyed_rotating_queue.sv
design/krq_checker.sv
dv/tb_top.sv
